// ----- rtl/core/cam_pkg.sv -----
package cam_pkg;

  localparam int FracBitsDefault = 14;
  localparam int SetW = 16;
  localparam int CoefW = 20;
  localparam int CordicIters = 24;
  localparam int AngW = 34;
  localparam int QueueDepth = 2;

  localparam logic signed [AngW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [AngW-1:0] CordicGainQ30 = 34'sd652032874;
  localparam logic signed [AngW-1:0] ThirdQ30 = 34'sd357913941;
  localparam logic signed [AngW-1:0] InvSqrt3Q30 = 34'sd619925131;

  typedef struct packed {
    logic signed [SetW-1:0] brightness;
    logic signed [SetW-1:0] contrast;
    logic signed [SetW-1:0] hue;
    logic signed [SetW-1:0] saturation;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              matrix_row;
    logic [1:0]              matrix_col;
    logic signed [CoefW-1:0] coefficient;
    logic                    last;
  } out_item_t;

  function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] i);
    logic signed [AngW-1:0] v;
    unique case (i)
      5'd0: v = 34'sh03243F6A8;
      5'd1: v = 34'sh01DAC6705;
      5'd2: v = 34'sh00FADBAFC;
      5'd3: v = 34'sh007F56EA6;
      5'd4: v = 34'sh003FEAB76;
      5'd5: v = 34'sh001FFD55B;
      5'd6: v = 34'sh000FFFAAA;
      5'd7: v = 34'sh0007FFF55;
      5'd8: v = 34'sh0003FFFEA;
      5'd9: v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/cam_front.sv -----
module cam_front #(
  parameter int FRAC_BITS = cam_pkg::FracBitsDefault,
  parameter int VW = FRAC_BITS + 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  cam_pkg::in_item_t       in_item,
  output logic                    busy,
  output logic                    q_vld,
  output logic signed [VW-1:0]    q_b,
  output logic signed [VW-1:0]    q_c,
  output logic signed [VW-1:0]    q_s,
  output logic signed [VW-1:0]    q_hc,
  output logic signed [VW-1:0]    q_hs,
  input  logic                    q_pop
);
  localparam int AW = cam_pkg::AngW;
  localparam int IW = $clog2(cam_pkg::CordicIters + 1);
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [VW-1:0] One = VW'(1) <<< FRAC_BITS;
  localparam int QD = cam_pkg::QueueDepth;
  localparam int QW = $clog2(QD + 1);
  localparam int QI = $clog2(QD);

  function automatic logic signed [VW-1:0] clampset(input logic signed [15:0] r);
    logic signed [VW-1:0] v;
    v = VW'(r);
    if (v > One) v = One;
    else if (v < -One) v = -One;
    return v;
  endfunction

  logic                  run_r, run_nxt;
  logic [IW-1:0]         it_r, it_nxt;
  logic signed [AW-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic                  flip_r, flip_nxt;
  logic signed [VW-1:0]  b_r, c_r, s_r;
  logic signed [VW-1:0]  hu;
  logic signed [AW+VW-1:0] zp;
  logic signed [AW-1:0]  z0;
  logic signed [AW-1:0]  xs, ys, xf, yf;
  logic signed [VW-1:0]  hc, hs;
  logic                  done;

  logic signed [VW-1:0]  qb_r [QD], qc_r [QD], qs_r [QD], qhc_r [QD], qhs_r [QD];
  logic [QW-1:0]         cnt_r;
  logic                  full;

  assign full = (cnt_r == QW'(QD));
  assign busy = run_r;
  assign done = run_r && (it_r == IW'(cam_pkg::CordicIters)) && !full;

  always_comb begin
    hu = clampset(in_item.hue);
    zp = (AW + VW)'(hu) * (AW + VW)'(cam_pkg::PiQ30)
       + ((AW + VW)'(1) <<< (FRAC_BITS - 1));
    z0 = AW'(zp >>> FRAC_BITS);
  end

  always_comb begin
    run_nxt = run_r;
    it_nxt = it_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    flip_nxt = flip_r;
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    if (!run_r && in_vld) begin
      run_nxt = 1'b1;
      it_nxt = '0;
      x_nxt = cam_pkg::CordicGainQ30;
      y_nxt = '0;
      if (z0 > cam_pkg::HalfPiQ30) begin
        z_nxt = z0 - cam_pkg::PiQ30;
        flip_nxt = 1'b1;
      end else if (z0 < -cam_pkg::HalfPiQ30) begin
        z_nxt = z0 + cam_pkg::PiQ30;
        flip_nxt = 1'b1;
      end else begin
        z_nxt = z0;
        flip_nxt = 1'b0;
      end
    end else if (run_r && it_r != IW'(cam_pkg::CordicIters)) begin
      it_nxt = it_r + IW'(1);
      if (!z_r[AW-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - cam_pkg::atan_q30(5'(it_r));
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + cam_pkg::atan_q30(5'(it_r));
      end
    end else if (done) begin
      run_nxt = 1'b0;
    end
  end

  always_comb begin
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    hc = VW'((xf + (AW'(1) <<< (SH - 1))) >>> SH);
    hs = VW'((yf + (AW'(1) <<< (SH - 1))) >>> SH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      it_r <= '0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      it_r <= it_nxt;
      if (done && !q_pop) cnt_r <= cnt_r + QW'(1);
      else if (!done && q_pop) cnt_r <= cnt_r - QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    flip_r <= flip_nxt;
    if (!run_r && in_vld) begin
      b_r <= (in_item.brightness < 0 ? clampset(in_item.brightness)
              : clampset(in_item.brightness) <<< 2) + One;
      c_r <= -clampset(in_item.contrast);
      s_r <= clampset(in_item.saturation) + One;
    end
    // pop with push only happens at one entry, so the push lands in the head
    if (q_pop && !done) begin
      for (int i = 0; i < QD - 1; i++) begin
        qb_r[i] <= qb_r[i+1];
        qc_r[i] <= qc_r[i+1];
        qs_r[i] <= qs_r[i+1];
        qhc_r[i] <= qhc_r[i+1];
        qhs_r[i] <= qhs_r[i+1];
      end
    end
    if (done) begin
      qb_r[QI'(cnt_r - QW'(q_pop))] <= b_r;
      qc_r[QI'(cnt_r - QW'(q_pop))] <= c_r;
      qs_r[QI'(cnt_r - QW'(q_pop))] <= s_r;
      qhc_r[QI'(cnt_r - QW'(q_pop))] <= hc;
      qhs_r[QI'(cnt_r - QW'(q_pop))] <= hs;
    end
  end

  assign q_vld = (cnt_r != '0);
  assign q_b = qb_r[0];
  assign q_c = qc_r[0];
  assign q_s = qs_r[0];
  assign q_hc = qhc_r[0];
  assign q_hs = qhs_r[0];

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= QW'(QD))
    else $error("queue overflow");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_vld)
    else $error("pop from empty queue");
  a_it: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && it_r != IW'(cam_pkg::CordicIters) |=> run_r)
    else $error("cordic aborted");
endmodule

// ----- rtl/core/cam_back.sv -----
module cam_back #(
  parameter int FRAC_BITS = cam_pkg::FracBitsDefault,
  parameter int VW = FRAC_BITS + 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_vld,
  input  logic signed [VW-1:0]  q_b,
  input  logic signed [VW-1:0]  q_c,
  input  logic signed [VW-1:0]  q_s,
  input  logic signed [VW-1:0]  q_hc,
  input  logic signed [VW-1:0]  q_hs,
  output logic                  q_pop,
  output logic                  out_strobe,
  output cam_pkg::out_item_t    out_item
);
  localparam int CW = cam_pkg::CoefW;
  localparam int PW = 2 * VW + 4;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [VW-1:0] One = VW'(1) <<< FRAC_BITS;
  localparam longint Sc = longint'(1) << FRAC_BITS;
  localparam logic signed [VW-1:0] Wr = VW'((3086 * Sc + 5000) / 10000);
  localparam logic signed [VW-1:0] Wg = VW'((6094 * Sc + 5000) / 10000);
  localparam logic signed [VW-1:0] Wb = VW'((820 * Sc + 5000) / 10000);
  localparam logic signed [VW-1:0] Nn =
    VW'((cam_pkg::ThirdQ30 + (34'sd1 <<< (SH - 1))) >>> SH);
  localparam logic signed [VW-1:0] Ninv =
    VW'((cam_pkg::InvSqrt3Q30 + (34'sd1 <<< (SH - 1))) >>> SH);

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_RUN} st_t;

  st_t                  st_r;
  logic [3:0]           k_r;
  logic signed [VW-1:0] bc_r [16];
  logic signed [VW-1:0] sm_r [16];
  logic signed [VW-1:0] hm_r [16];
  logic signed [VW-1:0] t_r [4];
  logic signed [VW-1:0] hc_r, hs_r, s_r, a_r, ns_r;
  logic                 ph_r;
  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] r1;
  logic signed [VW-1:0] tq;
  logic signed [PW-1:0] mv;
  logic signed [VW-1:0] u;

  function automatic logic signed [VW-1:0] qmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< (FRAC_BITS - 1));
    return VW'(p >>> FRAC_BITS);
  endfunction

  assign q_pop = (st_r == ST_IDLE) && q_vld;
  assign u = One - s_r;

  // BC*S entry at (row, col) of k_r, and M entry at k_r from the finished t row
  always_comb begin
    acc = '0;
    for (int j = 0; j < 4; j++)
      acc = acc + PW'(bc_r[{k_r[3:2], 2'(j)}]) * PW'(sm_r[{2'(j), k_r[1:0]}]);
    r1 = '0;
    for (int j = 0; j < 4; j++)
      r1 = r1 + PW'(t_r[j]) * PW'(hm_r[{2'(j), k_r[1:0]}]);
    tq = VW'((acc + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    mv = (r1 + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      k_r <= '0;
      ph_r <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (st_r == ST_RUN) && ph_r;
      unique case (st_r)
        ST_IDLE: begin
          if (q_vld) begin
            st_r <= ST_PREP;
            ph_r <= 1'b0;
          end
        end
        ST_PREP: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            st_r <= ST_RUN;
            k_r <= '0;
          end
        end
        ST_RUN: begin
          // per row: four steps build the t row, four steps emit
          if (!ph_r) begin
            if (k_r[1:0] == 2'd3) begin
              ph_r <= 1'b1;
              k_r <= {k_r[3:2], 2'd0};
            end else begin
              k_r <= k_r + 4'd1;
            end
          end else begin
            k_r <= k_r + 4'd1;
            if (k_r[1:0] == 2'd3) ph_r <= 1'b0;
            if (k_r == 4'd15) st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s_r <= q_s;
      hc_r <= q_hc;
      hs_r <= q_hs;
      bc_r[0] <= q_b;
      bc_r[1] <= '0;
      bc_r[2] <= '0;
      bc_r[3] <= '0;
      bc_r[4] <= '0;
      bc_r[5] <= q_b;
      bc_r[6] <= '0;
      bc_r[7] <= '0;
      bc_r[8] <= '0;
      bc_r[9] <= '0;
      bc_r[10] <= q_b;
      bc_r[11] <= '0;
      bc_r[12] <= q_c;
      bc_r[13] <= q_c;
      bc_r[14] <= q_c;
      bc_r[15] <= One;
    end
    if (st_r == ST_PREP && !ph_r) begin
      a_r <= qmul(Nn, One - hc_r);
      ns_r <= qmul(Ninv, hs_r);
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++) begin
          if (r < 3 && k < 3) begin
            sm_r[r*4+k] <= qmul(u, (k == 0) ? Wr : ((k == 1) ? Wg : Wb))
                           + ((r == k) ? s_r : '0);
          end else if (r == 3 && k == 3) begin
            sm_r[r*4+k] <= One;
          end else begin
            sm_r[r*4+k] <= '0;
          end
        end
      end
    end
    if (st_r == ST_PREP && ph_r) begin
      hm_r[0] <= a_r + hc_r; hm_r[1] <= a_r - ns_r; hm_r[2] <= a_r + ns_r;
      hm_r[4] <= a_r + ns_r; hm_r[5] <= a_r + hc_r; hm_r[6] <= a_r - ns_r;
      hm_r[8] <= a_r - ns_r; hm_r[9] <= a_r + ns_r; hm_r[10] <= a_r + hc_r;
      hm_r[3] <= '0; hm_r[7] <= '0; hm_r[11] <= '0;
      hm_r[12] <= '0; hm_r[13] <= '0; hm_r[14] <= '0;
      hm_r[15] <= One;
    end
    if (st_r == ST_RUN && !ph_r) t_r[k_r[1:0]] <= tq;
    if (st_r == ST_RUN && ph_r) begin
      out_item.matrix_row <= k_r[3:2];
      out_item.matrix_col <= k_r[1:0];
      out_item.last <= (k_r == 4'd15);
      if (mv > PW'((1 <<< (CW - 1)) - 1)) out_item.coefficient <= {1'b0, {(CW-1){1'b1}}};
      else if (mv < -PW'(1 <<< (CW - 1))) out_item.coefficient <= {1'b1, {(CW-1){1'b0}}};
      else out_item.coefficient <= CW'(mv);
    end
  end

  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_r == ST_PREP)
    else $error("pop without prep");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |=> !out_strobe)
    else $error("strobe after last");
  a_str: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |-> st_r == ST_RUN)
    else $error("strobe outside run");
endmodule

// ----- rtl/core/color_adjust_matrix_generator.sv -----
// Channel  Ports                        Handshake
// input    start, busy, in_item         accepted when start && !busy
// result   out_strobe, out_item         out_strobe marks each item, no stall
// Front: CORDIC per settings item (accept, 24 rotations, push), one at a time; the push waits while the queue is full.
// Back: a pop, then prep (S and the hue terms, then the hue matrix), then per row
// building a row of BC*S and emitting a row of the matrix.
// Sustained rate is set by the back, which pops a new item only once idle.
// A two-entry queue lets the front take the next item while the back emits.
// rst_n is synchronous, active low; results cannot be held off.
module color_adjust_matrix_generator #(
  parameter int FRAC_BITS = cam_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cam_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output cam_pkg::out_item_t out_item
);
  localparam int VW = FRAC_BITS + 6;

  logic                 q_vld, q_pop;
  logic signed [VW-1:0] q_b, q_c, q_s, q_hc, q_hs;

  cam_front #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_front (
    .clk, .rst_n, .in_vld(start), .in_item, .busy,
    .q_vld, .q_b, .q_c, .q_s, .q_hc, .q_hs, .q_pop
  );

  cam_back #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_back (
    .clk, .rst_n, .q_vld, .q_b, .q_c, .q_s, .q_hc, .q_hs, .q_pop,
    .out_strobe, .out_item
  );
endmodule
